@@ src/mtc1d_pkg.sv @@
`default_nettype none
package mtc1d_pkg;

   localparam int MAX_TAPS      = 8;
   localparam int MAX_ROW_WIDTH = 256;
   localparam int DATA_WIDTH    = 16;
   localparam int ACC_WIDTH     = 48;
   localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
   localparam int FRAC_SHIFT    = 10;
   localparam int TAP_WIDTH     = 3;
   localparam int EL_WIDTH      = 8;
   localparam int POS_WIDTH     = 16;
   localparam int RES_WIDTH     = 32;
   localparam int CSR_WIDTH     = 32;
   localparam int MID_DEPTH     = 4;
   localparam int OUT_DEPTH     = 8;

   typedef enum logic [1:0] {
      CSR_BIAS        = 2'd0,
      CSR_TAP_MASK    = 2'd1,
      CSR_TAPS_IN_USE = 2'd2,
      CSR_ROW_WIDTH   = 2'd3
   } csr_index_type;

   // effective configuration (clamped, bit 0 of mask forced)
   typedef struct packed {
      logic signed [RES_WIDTH-1:0] bias;
      logic [MAX_TAPS-1:0]         mask;
      logic [3:0]                  taps;
      logic [8:0]                  width;
   } cfg_type;

   typedef struct packed {
      logic                         is_data;
      logic [TAP_WIDTH-1:0]         tap;
      logic [EL_WIDTH-1:0]          addr;
      logic signed [DATA_WIDTH-1:0] value;
      logic                         row_end;
      logic                         last;
      logic                         emit;
      logic [TAP_WIDTH-1:0]         sel;
      logic [POS_WIDTH-1:0]         pos;
      logic                         short_seq;
   } op_type;

   typedef struct packed {
      logic signed [RES_WIDTH-1:0] result;
      logic [POS_WIDTH-1:0]        pos;
      logic                        final_res;
      logic                        short_seq;
   } res_type;

endpackage
`default_nettype wire

@@ src/mtc1d_ram.sv @@
`default_nettype none
module mtc1d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ src/mtc1d_fifo.sv @@
`default_nettype none
module mtc1d_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule
`default_nettype wire

@@ src/mtc1d_front.sv @@
`default_nettype none
module mtc1d_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   accept,
   input  wire logic                                   kind,
   input  wire logic [mtc1d_pkg::TAP_WIDTH-1:0]        tap,
   input  wire logic [mtc1d_pkg::EL_WIDTH-1:0]         element,
   input  wire logic signed [mtc1d_pkg::DATA_WIDTH-1:0] value,
   input  wire logic                                   last,
   input  wire mtc1d_pkg::cfg_type                     cfg,
   output mtc1d_pkg::op_type                           op
);
   logic [mtc1d_pkg::EL_WIDTH-1:0]  ec_ff, ec_in;
   logic [mtc1d_pkg::POS_WIDTH-1:0] row_ff, row_in;
   logic                            primed_ff, primed_in;
   logic [8:0]                      dm1;
   logic [mtc1d_pkg::EL_WIDTH-1:0]  j;
   logic [mtc1d_pkg::POS_WIDTH-1:0] hm1;
   logic                            row_end, full_win;

   always_comb begin
      dm1      = cfg.width - 9'd1;
      j        = ({1'b0, ec_ff} >= cfg.width) ? dm1[7:0] : ec_ff;
      row_end  = (j == dm1[7:0]) || last;
      hm1      = {12'd0, cfg.taps - 4'd1};
      full_win = primed_ff || (row_ff >= hm1);

      op.is_data   = kind;
      op.tap       = tap;
      op.addr      = kind ? j : element;
      op.value     = value;
      op.row_end   = row_end;
      op.last      = last;
      op.emit      = kind && row_end && (full_win || last);
      op.sel       = full_win ? hm1[2:0] : row_ff[2:0];
      op.pos       = full_win ? row_ff - hm1 : '0;
      op.short_seq = !full_win;

      ec_in     = ec_ff;
      row_in    = row_ff;
      primed_in = primed_ff;
      if (accept && kind) begin
         if (row_end) begin
            ec_in     = '0;
            row_in    = last ? '0 : row_ff + 16'd1;
            primed_in = last ? 1'b0 : full_win;
         end else begin
            ec_in = j + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ec_ff     <= '0;
         row_ff    <= '0;
         primed_ff <= 1'b0;
      end else begin
         ec_ff     <= ec_in;
         row_ff    <= row_in;
         primed_ff <= primed_in;
      end
   end
endmodule
`default_nettype wire

@@ src/mtc1d_back.sv @@
`default_nettype none
module mtc1d_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              issue,
   input  wire mtc1d_pkg::op_type op,
   input  wire mtc1d_pkg::cfg_type cfg,
   output logic                   res_valid,
   output mtc1d_pkg::res_type     res
);
   localparam int NT = mtc1d_pkg::MAX_TAPS;
   localparam int AW = mtc1d_pkg::ACC_WIDTH;
   localparam int PW = mtc1d_pkg::PROD_WIDTH;
   localparam int DW = mtc1d_pkg::DATA_WIDTH;
   localparam int FS = mtc1d_pkg::FRAC_SHIFT;
   localparam int SW = AW - FS + 2;

   logic signed [DW-1:0] w_rd [NT];

   // stage 1: weight read in flight
   logic                 s1_valid_ff;
   mtc1d_pkg::op_type    s1_op_ff;
   // stage 2: products
   logic                 s2_valid_ff;
   mtc1d_pkg::op_type    s2_op_ff;
   logic signed [PW-1:0] prod_ff [NT];
   logic signed [PW-1:0] prod_in [NT];
   // stage 3: accumulators and the captured window sum
   logic signed [AW-1:0] ps_ff [NT];
   logic signed [AW-1:0] ps_in [NT];
   logic signed [AW-1:0] acc   [NT];
   logic                 s3_valid_ff;
   mtc1d_pkg::op_type    s3_op_ff;
   logic signed [AW-1:0] sum_ff;

   for (genvar k = 0; k < NT; k++) begin : g_tap
      mtc1d_ram #(.WIDTH(DW), .DEPTH(mtc1d_pkg::MAX_ROW_WIDTH)) u_wram (
         .clock (clock),
         .we    (issue && !op.is_data && (op.tap == mtc1d_pkg::TAP_WIDTH'(k))),
         .waddr (op.addr),
         .wdata (op.value),
         .raddr (op.addr),
         .rdata (w_rd[k])
      );
   end

   always_comb begin
      logic signed [AW:0] s;
      for (int k = 0; k < NT; k++) begin
         if ((cfg.taps > 4'(k)) && cfg.mask[k]) begin
            prod_in[k] = s1_op_ff.value * w_rd[k];
         end else begin
            prod_in[k] = '0;
         end
         s = {ps_ff[k][AW-1], ps_ff[k]} + (AW+1)'(prod_ff[k]);
         if (s[AW] != s[AW-1]) begin
            acc[k] = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
         end else begin
            acc[k] = s[AW-1:0];
         end
      end
      for (int k = 0; k < NT; k++) begin
         ps_in[k] = ps_ff[k];
         if (s2_valid_ff) begin
            if (s2_op_ff.last) begin
               ps_in[k] = '0;
            end else if (s2_op_ff.row_end) begin
               ps_in[k] = (k == 0) ? '0 : acc[(k == 0) ? 0 : k - 1];
            end else begin
               ps_in[k] = acc[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         for (int k = 0; k < NT; k++) begin
            ps_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff <= issue && op.is_data;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && s2_op_ff.emit;
         for (int k = 0; k < NT; k++) begin
            ps_ff[k] <= ps_in[k];
         end
      end
      s1_op_ff <= op;
      s2_op_ff <= s1_op_ff;
      s3_op_ff <= s2_op_ff;
      sum_ff   <= acc[s2_op_ff.sel];
      for (int k = 0; k < NT; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   // output: round half up at bit FS, add bias, saturate to 32 bits
   always_comb begin
      logic signed [AW-1:0] sh;
      logic signed [SW-1:0] tot;
      sh  = sum_ff >>> FS;
      tot = SW'($signed(sh[AW-FS-1:0])) + SW'({1'b0, sum_ff[FS-1]})
            + SW'($signed(cfg.bias));
      if (tot > SW'(64'sh7FFF_FFFF)) begin
         res.result = 32'sh7FFF_FFFF;
      end else if (tot < -SW'(64'sh8000_0000)) begin
         res.result = 32'sh8000_0000;
      end else begin
         res.result = tot[mtc1d_pkg::RES_WIDTH-1:0];
      end
      res.pos       = s3_op_ff.pos;
      res.final_res = s3_op_ff.last;
      res.short_seq = s3_op_ff.short_seq;
   end

   assign res_valid = s3_valid_ff;
endmodule
`default_nettype wire

@@ src/masked_tap_conv1d_unit.sv @@
// Throughput: one transaction per cycle; set by the single multiply-accumulate pass
// per element through 8 tap weight RAMs, and by room in the 8-entry result queue.
// Reset: synchronous, active high; clears row state, accumulators, queues and
// config (bias 0, mask 1, taps 1, width 256). Weight RAMs are not cleared.
`default_nettype none
module masked_tap_conv1d_unit #(
   parameter int MID_DEPTH = mtc1d_pkg::MID_DEPTH,
   parameter int OUT_DEPTH = mtc1d_pkg::OUT_DEPTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // input queue side
   input  wire logic                                    push,
   output logic                                         full,
   input  wire logic                                    req_kind,
   input  wire logic [mtc1d_pkg::TAP_WIDTH-1:0]         req_tap,
   input  wire logic [mtc1d_pkg::EL_WIDTH-1:0]          req_element,
   input  wire logic signed [mtc1d_pkg::DATA_WIDTH-1:0] req_value,
   input  wire logic                                    req_last,
   // result queue side
   output logic                                         empty,
   input  wire logic                                    pop,
   output logic signed [mtc1d_pkg::RES_WIDTH-1:0]       rsp_result,
   output logic [mtc1d_pkg::POS_WIDTH-1:0]              rsp_position,
   output logic                                         rsp_final_res,
   output logic                                         rsp_short_sequence,
   // config writes
   input  wire logic                                    csr_we,
   input  wire logic [1:0]                              csr_index,
   input  wire logic [mtc1d_pkg::CSR_WIDTH-1:0]         csr_wdata
);
   localparam int RCW = $clog2(OUT_DEPTH + 1);

   // raw config registers
   logic signed [31:0] bias_ff;
   logic [7:0]         mask_ff;
   logic [3:0]         taps_ff;
   logic [8:0]         width_ff;
   mtc1d_pkg::cfg_type cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff  <= '0;
         mask_ff  <= 8'd1;
         taps_ff  <= 4'd1;
         width_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (mtc1d_pkg::csr_index_type'(csr_index))
            mtc1d_pkg::CSR_BIAS:        bias_ff  <= csr_wdata;
            mtc1d_pkg::CSR_TAP_MASK:    mask_ff  <= csr_wdata[7:0];
            mtc1d_pkg::CSR_TAPS_IN_USE: taps_ff  <= csr_wdata[3:0];
            mtc1d_pkg::CSR_ROW_WIDTH:   width_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // effective values: zero means one, large values clamp
   always_comb begin
      cfg.bias  = bias_ff;
      cfg.mask  = mask_ff | 8'd1;
      cfg.taps  = (taps_ff == 4'd0) ? 4'd1 : ((taps_ff > 4'd8) ? 4'd8 : taps_ff);
      cfg.width = (width_ff == 9'd0) ? 9'd1 :
                  ((width_ff > 9'd256) ? 9'd256 : width_ff);
   end

   // front: classify, track element/row position, decide emission
   logic              accept;
   mtc1d_pkg::op_type front_op, head_op;
   logic              mid_full, mid_empty, issue;

   assign accept = push && !mid_full;
   assign full   = mid_full;

   mtc1d_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .kind    (req_kind),
      .tap     (req_tap),
      .element (req_element),
      .value   (req_value),
      .last    (req_last),
      .cfg     (cfg),
      .op      (front_op)
   );

   // decoupling queue between front and back
   mtc1d_fifo #(.WIDTH($bits(mtc1d_pkg::op_type)), .DEPTH(MID_DEPTH)) u_mid (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .wdata (front_op),
      .pop   (issue),
      .rdata (head_op),
      .full  (mid_full),
      .empty (mid_empty)
   );

   // credits: a result-producing transaction only enters the back end when a
   // result queue slot is reserved for it, so the back end never stalls
   logic [RCW-1:0] resv_ff, resv_in;
   logic           out_pop;

   assign issue = !mid_empty && (!head_op.emit || (resv_ff < RCW'(OUT_DEPTH)));

   always_comb begin
      resv_in = resv_ff;
      if ((issue && head_op.emit) && !out_pop) begin
         resv_in = resv_ff + RCW'(1);
      end else if (!(issue && head_op.emit) && out_pop) begin
         resv_in = resv_ff - RCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resv_ff <= '0;
      end else begin
         resv_ff <= resv_in;
      end
   end

   // back: weight RAMs, multipliers, accumulator ring, output rounding
   logic               res_valid;
   mtc1d_pkg::res_type res, out_res;
   logic               out_full;

   mtc1d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .op        (head_op),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   mtc1d_fifo #(.WIDTH($bits(mtc1d_pkg::res_type)), .DEPTH(OUT_DEPTH)) u_out (
      .clock (clock),
      .reset (reset),
      .push  (res_valid),
      .wdata (res),
      .pop   (pop),
      .rdata (out_res),
      .full  (out_full),
      .empty (empty)
   );

   assign out_pop            = pop && !empty;
   assign rsp_result         = out_res.result;
   assign rsp_position       = out_res.pos;
   assign rsp_final_res      = out_res.final_res;
   assign rsp_short_sequence = out_res.short_seq;

`ifndef SYNTHESIS
   a_resv_bound : assert property (@(posedge clock) disable iff (reset)
      resv_ff <= RCW'(OUT_DEPTH))
      else $error("result credit count overflow");
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !out_full)
      else $error("result written into full queue");
   a_pop_has_credit : assert property (@(posedge clock) disable iff (reset)
      !empty |-> (resv_ff != '0))
      else $error("queued result without reservation");
`endif
endmodule
`default_nettype wire

@@ sim/tb_masked_tap_conv1d_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_masked_tap_conv1d_unit;

   // Window model: mirrors the conv datapath state and the register set.
   // Every accepted input transaction goes through accept_item(), and every
   // popped result goes through compare_output() against the oldest prediction.
   class conv_window_model;
      logic signed [mtc1d_pkg::DATA_WIDTH-1:0]
         weights [mtc1d_pkg::MAX_TAPS][mtc1d_pkg::MAX_ROW_WIDTH];
      longint  tap_sums [mtc1d_pkg::MAX_TAPS];
      int      elem_cnt, row_cnt;
      bit      primed;
      longint  bias;
      int      mask, taps, width;
      mtc1d_pkg::res_type pending_outputs[$];
      int      mismatches, outputs_seen, short_seen;

      function new();
         foreach (tap_sums[k]) tap_sums[k] = 0;
         elem_cnt = 0; row_cnt = 0; primed = 0;
         bias = 0; mask = 1; taps = 1; width = 256;
         mismatches = 0; outputs_seen = 0; short_seen = 0;
      endfunction

      function void write_reg(mtc1d_pkg::csr_index_type idx,
                              logic [mtc1d_pkg::CSR_WIDTH-1:0] data);
         case (idx)
            mtc1d_pkg::CSR_BIAS:        bias  = longint'($signed(data));
            mtc1d_pkg::CSR_TAP_MASK:    mask  = int'(data[7:0]);
            mtc1d_pkg::CSR_TAPS_IN_USE: taps  = int'(data[3:0]);
            mtc1d_pkg::CSR_ROW_WIDTH:   width = int'(data[8:0]);
            default: ;
         endcase
      endfunction

      // saturating add at accumulator width
      function longint acc_add(longint a, longint b);
         longint hi, lo, s;
         hi = (longint'(1) <<< (mtc1d_pkg::ACC_WIDTH - 1)) - 1;
         lo = -hi - 1;
         s  = a + b;
         if (s > hi) return hi;
         if (s < lo) return lo;
         return s;
      endfunction

      // Q.26 sum -> Q16.16, round half up, add bias, clamp to 32 bit
      function logic signed [mtc1d_pkg::RES_WIDTH-1:0] to_q16(longint s);
         longint r, f;
         r = s >>> mtc1d_pkg::FRAC_SHIFT;
         f = s - (r <<< mtc1d_pkg::FRAC_SHIFT);
         if (f >= (longint'(1) <<< (mtc1d_pkg::FRAC_SHIFT - 1))) r++;
         r += bias;
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r[31:0];
      endfunction

      function void accept_item(logic kind, logic [mtc1d_pkg::TAP_WIDTH-1:0] tap,
                                logic [mtc1d_pkg::EL_WIDTH-1:0] el,
                                logic signed [mtc1d_pkg::DATA_WIDTH-1:0] val,
                                logic last);
         int      h, d, j, r, m;
         mtc1d_pkg::res_type o;
         if (!kind) begin
            weights[tap][el] = val;
            return;
         end
         h = (taps == 0) ? 1 :
             ((taps > mtc1d_pkg::MAX_TAPS) ? mtc1d_pkg::MAX_TAPS : taps);
         d = (width == 0) ? 1 :
             ((width > mtc1d_pkg::MAX_ROW_WIDTH) ? mtc1d_pkg::MAX_ROW_WIDTH : width);
         m = mask | 1;
         j = (elem_cnt >= d) ? d - 1 : elem_cnt;
         for (int k = 0; k < h; k++)
            if (m[k])
               tap_sums[k] = acc_add(tap_sums[k], longint'(val) * longint'(weights[k][j]));
         if (j != d - 1 && !last) begin
            elem_cnt = j + 1;
            return;
         end
         elem_cnt = 0;
         r = row_cnt;
         if (primed || r >= h - 1) begin
            o.result = to_q16(tap_sums[h-1]);
            o.pos = 16'(r - (h - 1));
            o.final_res = last;
            o.short_seq = 1'b0;
            pending_outputs.push_back(o);
            primed = 1;
         end else if (last) begin
            o.result = to_q16(tap_sums[r]);
            o.pos = '0;
            o.final_res = 1'b1;
            o.short_seq = 1'b1;
            pending_outputs.push_back(o);
         end
         for (int k = mtc1d_pkg::MAX_TAPS - 1; k > 0; k--) tap_sums[k] = tap_sums[k-1];
         tap_sums[0] = 0;
         row_cnt = (r + 1) & 16'hffff;
         if (last) begin
            foreach (tap_sums[k]) tap_sums[k] = 0;
            row_cnt = 0;
            primed = 0;
         end
      endfunction

      function void compare_output(mtc1d_pkg::res_type got);
         mtc1d_pkg::res_type want;
         outputs_seen++;
         if (pending_outputs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result transaction result=%0d pos=%0d",
                        got.result, got.pos);
            return;
         end
         want = pending_outputs.pop_front();
         if (want.short_seq) short_seen++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                        want.result, want.pos, want.final_res, want.short_seq,
                        got.result, got.pos, got.final_res, got.short_seq);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0, pop = 1'b0, full, empty;
   logic req_kind = 1'b0, req_last = 1'b0;
   logic [mtc1d_pkg::TAP_WIDTH-1:0] req_tap = '0;
   logic [mtc1d_pkg::EL_WIDTH-1:0] req_element = '0;
   logic signed [mtc1d_pkg::DATA_WIDTH-1:0] req_value = '0;
   logic signed [mtc1d_pkg::RES_WIDTH-1:0] rsp_result;
   logic [mtc1d_pkg::POS_WIDTH-1:0] rsp_position;
   logic rsp_final_res, rsp_short_sequence;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [mtc1d_pkg::CSR_WIDTH-1:0] csr_wdata = '0;

   conv_window_model model = new();
   int send_idle_pct = 0;   // chance of a sender gap after each transaction
   int recv_stall_pct = 0;  // chance pop stays low in a cycle
   int idle_cycles = 0;
   int items_sent = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   masked_tap_conv1d_unit u_dut (
      .clock, .reset, .push, .full, .req_kind, .req_tap, .req_element,
      .req_value, .req_last, .empty, .pop, .rsp_result, .rsp_position,
      .rsp_final_res, .rsp_short_sequence, .csr_we, .csr_index, .csr_wdata
   );

   // result side: random back-pressure on pop, check on every accepted pop
   always @(negedge clock) begin
      pop = ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty)
         model.compare_output({rsp_result, rsp_position, rsp_final_res, rsp_short_sequence});
   end

   // watchdog: count cycles with no transaction on either side
   always @(posedge clock) begin
      if (!reset && ((push && !full) || (pop && !empty)))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: watchdog expired, no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one input transaction; push stays high into the next one unless a gap is drawn
   task automatic send_item(logic kind, logic [mtc1d_pkg::TAP_WIDTH-1:0] tap,
                            logic [mtc1d_pkg::EL_WIDTH-1:0] el,
                            logic signed [mtc1d_pkg::DATA_WIDTH-1:0] val, logic last);
      int gap;
      @(negedge clock);
      push = 1'b1;
      req_kind = kind; req_tap = tap; req_element = el;
      req_value = val; req_last = last;
      do @(posedge clock); while (full);
      model.accept_item(kind, tap, el, val, last);
      items_sent++;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         push = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold input off until every predicted result is out and the pipe is quiet
   task automatic drain();
      @(negedge clock);
      push = 1'b0;
      while (model.pending_outputs.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(mtc1d_pkg::csr_index_type idx,
                            logic [mtc1d_pkg::CSR_WIDTH-1:0] data);
      @(negedge clock);
      csr_we = 1'b1; csr_index = idx; csr_wdata = data;
      model.write_reg(idx, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   function automatic logic signed [mtc1d_pkg::DATA_WIDTH-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         default: return mtc1d_pkg::DATA_WIDTH'($urandom);
      endcase
   endfunction

   // one sequence of rows; an early end stops after `cut` elements of the final row
   task automatic send_sequence(int rows, int width, int cut);
      for (int r = 0; r < rows; r++)
         for (int e = 0; e < width; e++) begin
            if (r == rows - 1 && cut > 0 && e == cut - 1) begin
               send_item(1'b1, mtc1d_pkg::TAP_WIDTH'($urandom),
                         mtc1d_pkg::EL_WIDTH'($urandom), rand_value(), 1'b1);
               return;
            end
            send_item(1'b1, mtc1d_pkg::TAP_WIDTH'($urandom),
                      mtc1d_pkg::EL_WIDTH'($urandom), rand_value(),
                      (r == rows - 1 && e == width - 1));
         end
   endtask

   initial begin
      int h, d, n;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // weights for the first 16 elements of every tap; data never reads past them
      for (int k = 0; k < mtc1d_pkg::MAX_TAPS; k++)
         for (int e = 0; e < 16; e++)
            send_item(1'b0, mtc1d_pkg::TAP_WIDTH'(k), mtc1d_pkg::EL_WIDTH'(e),
                      rand_value(), 1'b0);
      // extreme weight, last bit ignored
      send_item(1'b0, mtc1d_pkg::TAP_WIDTH'(0), mtc1d_pkg::EL_WIDTH'(0), 16'sh8000, 1'b1);
      // top corner of the store
      send_item(1'b0, mtc1d_pkg::TAP_WIDTH'(7), mtc1d_pkg::EL_WIDTH'(255), 16'sh7fff, 1'b0);

      // reset config: one tap, 256 wide; early last closes the single row
      send_item(1'b1, mtc1d_pkg::TAP_WIDTH'(0), mtc1d_pkg::EL_WIDTH'(0), 16'sh8000, 1'b1);
      send_sequence(1, 256, 3);
      drain();

      // all registers written; short sequence, then a full one
      write_reg(mtc1d_pkg::CSR_BIAS, 32'h7fffffff);
      write_reg(mtc1d_pkg::CSR_TAP_MASK, 32'h0);
      write_reg(mtc1d_pkg::CSR_TAPS_IN_USE, 4);
      write_reg(mtc1d_pkg::CSR_ROW_WIDTH, 2);
      send_sequence(2, 2, 0);
      send_sequence(6, 2, 0);
      drain();

      // zero height and zero width act as one; then oversize both
      write_reg(mtc1d_pkg::CSR_BIAS, 32'h80000000);
      write_reg(mtc1d_pkg::CSR_TAP_MASK, 32'hff);
      write_reg(mtc1d_pkg::CSR_TAPS_IN_USE, 0);
      write_reg(mtc1d_pkg::CSR_ROW_WIDTH, 0);
      send_sequence(3, 1, 0);
      drain();
      write_reg(mtc1d_pkg::CSR_TAPS_IN_USE, 15);
      write_reg(mtc1d_pkg::CSR_ROW_WIDTH, 511);
      send_sequence(1, 256, 4);
      drain();

      // width shrinks while a row is half done
      write_reg(mtc1d_pkg::CSR_TAPS_IN_USE, 2);
      write_reg(mtc1d_pkg::CSR_ROW_WIDTH, 4);
      write_reg(mtc1d_pkg::CSR_BIAS, 0);
      for (int e = 0; e < 3; e++)
         send_item(1'b1, mtc1d_pkg::TAP_WIDTH'(0), mtc1d_pkg::EL_WIDTH'(0),
                   rand_value(), 1'b0);
      drain();
      write_reg(mtc1d_pkg::CSR_ROW_WIDTH, 2);
      send_sequence(3, 2, 0);
      drain();

      // random phases, cycling through the idle/stall mixes
      for (int p = 0; p < 12; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
         endcase
         if (p == 0) begin
            h = 8; d = 16;
            write_reg(mtc1d_pkg::CSR_TAP_MASK, 32'hff);
            write_reg(mtc1d_pkg::CSR_BIAS, 32'h80000000);
         end else if (p == 1) begin
            h = 1; d = 1;
            write_reg(mtc1d_pkg::CSR_TAP_MASK, 32'h0);
            write_reg(mtc1d_pkg::CSR_BIAS, 32'h7fffffff);
         end else begin
            h = $urandom_range(1, 8); d = $urandom_range(1, 16);
            write_reg(mtc1d_pkg::CSR_TAP_MASK, $urandom_range(0, 255));
            write_reg(mtc1d_pkg::CSR_BIAS, $urandom);
         end
         write_reg(mtc1d_pkg::CSR_TAPS_IN_USE, h);
         write_reg(mtc1d_pkg::CSR_ROW_WIDTH, d);
         n = items_sent;
         while (items_sent - n < 115) begin
            if ($urandom_range(0, 9) == 0)
               send_item(1'b0, mtc1d_pkg::TAP_WIDTH'($urandom),
                         mtc1d_pkg::EL_WIDTH'($urandom), rand_value(), 1'($urandom));
            else
               send_sequence($urandom_range(1, h + 4), d,
                             ($urandom_range(0, 19) == 0) ? $urandom_range(1, d) : 0);
         end
         drain();
      end

      $display("Run covered %0d input transactions and %0d results (%0d short sequences)",
               items_sent, model.outputs_seen, model.short_seen);
      $display("over 12 random register settings plus directed extremes and idle mixes.");
      if (model.mismatches == 0 && model.pending_outputs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("ERROR: %0d mismatches, %0d results never arrived",
                  model.mismatches, model.pending_outputs.size());
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
